[sv/tlqe_pkg.sv]
// Shared widths, sideband type and saturation helper for the thick line quad expander.
`timescale 1ns / 1ps
package tlqe_pkg;
    localparam int CW        = 24;
    localparam int DW        = CW + 1;
    localparam int MW        = CW;
    localparam int LWW       = 16;
    localparam logic [LWW-1:0] LW_RESET = 16'd1280;
    localparam int KW        = LWW + 6;
    localparam int NUMW      = MW + KW;
    localparam int SQRW      = 64;
    localparam int ROOTW     = SQRW / 2;
    localparam int SQ_STAGES = ROOTW;
    localparam int DIVNW     = NUMW + 1;
    localparam int QW        = LWW + 1;
    localparam int CMPW      = DIVNW + 2;
    localparam int OFFW      = QW + 1;
    localparam int SUMW      = CW + 2;
    localparam int LAT       = SQ_STAGES + 1 + QW;

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic                 negx;
        logic                 negy;
        logic                 degen;
    } side_t;

    function automatic logic signed [CW-1:0] sat(input logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] hi;
        logic signed [SUMW-1:0] lo;
        hi = SUMW'((SUMW'(1) << (CW - 1)) - SUMW'(1));
        lo = -hi - SUMW'(1);
        if (v > hi)
        begin
            return hi[CW-1:0];
        end
        else if (v < lo)
        begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction
endpackage

[sv/tlqe_front.sv]
// Front end: differences, magnitudes, squares, numerators, scaled square sum.
`timescale 1ns / 1ps
module tlqe_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [tlqe_pkg::CW-1:0] start_x,
    input  logic signed [tlqe_pkg::CW-1:0] start_y,
    input  logic signed [tlqe_pkg::CW-1:0] end_x,
    input  logic signed [tlqe_pkg::CW-1:0] end_y,
    input  logic [tlqe_pkg::LWW-1:0]       line_width,
    output logic                          out_valid,
    output tlqe_pkg::side_t               side,
    output logic [tlqe_pkg::SQRW-1:0]     sq_in,
    output logic [tlqe_pkg::NUMW-1:0]     num_x,
    output logic [tlqe_pkg::NUMW-1:0]     num_y
);
    logic signed [tlqe_pkg::DW-1:0] dx;
    logic signed [tlqe_pkg::DW-1:0] dy;
    logic signed [tlqe_pkg::DW-1:0] dxa;
    logic signed [tlqe_pkg::DW-1:0] dya;
    logic [tlqe_pkg::KW-1:0]        k;

    logic                     va_reg, vb_reg, vc_reg;
    tlqe_pkg::side_t          sa_reg, sb_reg, sc_reg;
    tlqe_pkg::side_t          sa_next;
    logic [tlqe_pkg::MW-1:0]  ax_reg, ay_reg;
    logic [2*tlqe_pkg::MW-1:0] sqx_reg, sqy_reg;
    logic [tlqe_pkg::NUMW-1:0] nxb_reg, nyb_reg, nxc_reg, nyc_reg;
    logic [tlqe_pkg::SQRW-1:0] sq_reg;

    always_comb
    begin
        dx  = tlqe_pkg::DW'(end_x) - tlqe_pkg::DW'(start_x);
        dy  = tlqe_pkg::DW'(end_y) - tlqe_pkg::DW'(start_y);
        dxa = dx[tlqe_pkg::DW-1] ? -dx : dx;
        dya = dy[tlqe_pkg::DW-1] ? -dy : dy;
        k   = {line_width, 6'b0};
        sa_next.sx    = start_x;
        sa_next.sy    = start_y;
        sa_next.ex    = end_x;
        sa_next.ey    = end_y;
        sa_next.negx  = ~dy[tlqe_pkg::DW-1];
        sa_next.negy  = dx[tlqe_pkg::DW-1];
        sa_next.degen = (dx == '0) && (dy == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg  <= sa_next;
            ax_reg  <= dxa[tlqe_pkg::MW-1:0];
            ay_reg  <= dya[tlqe_pkg::MW-1:0];
            sb_reg  <= sa_reg;
            sqx_reg <= ax_reg * ax_reg;
            sqy_reg <= ay_reg * ay_reg;
            nxb_reg <= tlqe_pkg::NUMW'(ay_reg) * tlqe_pkg::NUMW'(k);
            nyb_reg <= tlqe_pkg::NUMW'(ax_reg) * tlqe_pkg::NUMW'(k);
            sc_reg  <= sb_reg;
            sq_reg  <= (tlqe_pkg::SQRW'(sqx_reg) + tlqe_pkg::SQRW'(sqy_reg)) << 14;
            nxc_reg <= nxb_reg;
            nyc_reg <= nyb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign side      = sc_reg;
    assign sq_in     = sq_reg;
    assign num_x     = nxc_reg;
    assign num_y     = nyc_reg;
endmodule

[sv/tlqe_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module tlqe_sqrt (
    input  logic                           clk,
    input  logic                           en,
    input  logic [tlqe_pkg::SQRW-1:0]      n_in,
    output logic [tlqe_pkg::ROOTW-1:0]     root
);
    logic [tlqe_pkg::SQRW-1:0] n_reg   [0:tlqe_pkg::SQ_STAGES-1];
    logic [tlqe_pkg::SQRW-1:0] res_reg [0:tlqe_pkg::SQ_STAGES-1];

    for (genvar g = 0; g < tlqe_pkg::SQ_STAGES; g++)
    begin : g_stage
        localparam logic [tlqe_pkg::SQRW-1:0] BITC =
            tlqe_pkg::SQRW'(1) << (tlqe_pkg::SQRW - 2 - 2 * g);
        logic [tlqe_pkg::SQRW-1:0] n_cur;
        logic [tlqe_pkg::SQRW-1:0] r_cur;
        logic [tlqe_pkg::SQRW-1:0] trial;
        if (g == 0)
        begin : g_first
            assign n_cur = n_in;
            assign r_cur = '0;
        end
        else
        begin : g_rest
            assign n_cur = n_reg[g-1];
            assign r_cur = res_reg[g-1];
        end
        assign trial = r_cur + BITC;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_cur >= trial)
                begin
                    n_reg[g]   <= n_cur - trial;
                    res_reg[g] <= (r_cur >> 1) + BITC;
                end
                else
                begin
                    n_reg[g]   <= n_cur;
                    res_reg[g] <= r_cur >> 1;
                end
            end
        end
    end

    assign root = res_reg[tlqe_pkg::SQ_STAGES-1][tlqe_pkg::ROOTW-1:0];
endmodule

[sv/tlqe_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module tlqe_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [tlqe_pkg::DIVNW-1:0]  num,
    input  logic [tlqe_pkg::ROOTW-1:0]  den,
    output logic [tlqe_pkg::QW-1:0]     quo
);
    logic [tlqe_pkg::DIVNW-1:0] rem_reg [0:tlqe_pkg::QW-1];
    logic [tlqe_pkg::ROOTW-1:0] den_reg [0:tlqe_pkg::QW-1];
    logic [tlqe_pkg::QW-1:0]    q_reg   [0:tlqe_pkg::QW-1];

    for (genvar g = 0; g < tlqe_pkg::QW; g++)
    begin : g_stage
        localparam int SH = tlqe_pkg::QW - 1 - g;
        logic [tlqe_pkg::DIVNW-1:0] r_cur;
        logic [tlqe_pkg::ROOTW-1:0] d_cur;
        logic [tlqe_pkg::QW-1:0]    q_cur;
        logic [tlqe_pkg::CMPW-1:0]  d_sh;
        if (g == 0)
        begin : g_first
            assign r_cur = num;
            assign d_cur = den;
            assign q_cur = '0;
        end
        else
        begin : g_rest
            assign r_cur = rem_reg[g-1];
            assign d_cur = den_reg[g-1];
            assign q_cur = q_reg[g-1];
        end
        assign d_sh = tlqe_pkg::CMPW'(d_cur) << SH;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[g] <= d_cur;
                if (tlqe_pkg::CMPW'(r_cur) >= d_sh)
                begin
                    rem_reg[g] <= tlqe_pkg::DIVNW'(tlqe_pkg::CMPW'(r_cur) - d_sh);
                    q_reg[g]   <= q_cur | (tlqe_pkg::QW'(1) << SH);
                end
                else
                begin
                    rem_reg[g] <= r_cur;
                    q_reg[g]   <= q_cur;
                end
            end
        end
    end

    assign quo = q_reg[tlqe_pkg::QW-1];
endmodule

[sv/thick_line_quad_expand_core.sv]
// Top level: thick line to quad expansion pipeline with config register and output stage.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_stall  | start_x, start_y, end_x, end_y
//  output   | out_valid / out_stall| corner0..3_x/_y, degenerate
//  config   | line_width_we        | line_width_data
//
// One transaction per cycle while out_stall does not freeze the pipe: 3 front stages, 32 square root
// stages (one root bit each), a rounding stage, 17 divider stages, output stage.
// Reset clears valid bits and sets line_width to 5.0.
// A stalled output freezes the whole pipe; in_stall follows at once.
`timescale 1ns / 1ps
module thick_line_quad_expand_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           line_width_we,
    input  logic [tlqe_pkg::LWW-1:0]       line_width_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [tlqe_pkg::CW-1:0] start_x,
    input  logic signed [tlqe_pkg::CW-1:0] start_y,
    input  logic signed [tlqe_pkg::CW-1:0] end_x,
    input  logic signed [tlqe_pkg::CW-1:0] end_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [tlqe_pkg::CW-1:0] corner0_x,
    output logic signed [tlqe_pkg::CW-1:0] corner0_y,
    output logic signed [tlqe_pkg::CW-1:0] corner1_x,
    output logic signed [tlqe_pkg::CW-1:0] corner1_y,
    output logic signed [tlqe_pkg::CW-1:0] corner2_x,
    output logic signed [tlqe_pkg::CW-1:0] corner2_y,
    output logic signed [tlqe_pkg::CW-1:0] corner3_x,
    output logic signed [tlqe_pkg::CW-1:0] corner3_y,
    output logic                           degenerate
);
    logic                       adv;
    logic [tlqe_pkg::LWW-1:0]   line_width_reg;
    logic                       f_valid;
    tlqe_pkg::side_t            f_side;
    logic [tlqe_pkg::SQRW-1:0]  f_sq;
    logic [tlqe_pkg::NUMW-1:0]  f_nx, f_ny;
    logic [tlqe_pkg::ROOTW-1:0] root;

    logic                       v_reg    [0:tlqe_pkg::LAT-1];
    tlqe_pkg::side_t            side_reg [0:tlqe_pkg::LAT-1];
    logic [tlqe_pkg::NUMW-1:0]  nx_reg   [0:tlqe_pkg::SQ_STAGES-1];
    logic [tlqe_pkg::NUMW-1:0]  ny_reg   [0:tlqe_pkg::SQ_STAGES-1];

    logic [tlqe_pkg::DIVNW-1:0] rnx_reg, rny_reg;
    logic [tlqe_pkg::ROOTW-1:0] den_reg;
    logic [tlqe_pkg::ROOTW-1:0] den_next;
    logic [tlqe_pkg::QW-1:0]    qx, qy;

    logic signed [tlqe_pkg::OFFW-1:0] ox, oy;
    tlqe_pkg::side_t                  last;
    logic                             out_valid_reg;
    logic signed [tlqe_pkg::CW-1:0]   c0x_reg, c0y_reg, c1x_reg, c1y_reg;
    logic signed [tlqe_pkg::CW-1:0]   c2x_reg, c2y_reg, c3x_reg, c3y_reg;
    logic                             degen_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= tlqe_pkg::LW_RESET;
        end
        else if (line_width_we)
        begin
            line_width_reg <= line_width_data;
        end
    end

    tlqe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (in_valid),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .line_width (line_width_reg),
        .out_valid  (f_valid),
        .side       (f_side),
        .sq_in      (f_sq),
        .num_x      (f_nx),
        .num_y      (f_ny)
    );

    tlqe_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .n_in (f_sq),
        .root (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tlqe_pkg::LAT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= f_valid;
            for (int i = 1; i < tlqe_pkg::LAT; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= f_side;
            for (int i = 1; i < tlqe_pkg::LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            nx_reg[0] <= f_nx;
            ny_reg[0] <= f_ny;
            for (int i = 1; i < tlqe_pkg::SQ_STAGES; i++)
            begin
                nx_reg[i] <= nx_reg[i-1];
                ny_reg[i] <= ny_reg[i-1];
            end
        end
    end

    // divide-by-zero guard: degenerate segments have zero numerators
    assign den_next = side_reg[tlqe_pkg::SQ_STAGES-1].degen ? tlqe_pkg::ROOTW'(1) : root;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg <= den_next;
            rnx_reg <= tlqe_pkg::DIVNW'(nx_reg[tlqe_pkg::SQ_STAGES-1])
                     + tlqe_pkg::DIVNW'(den_next >> 1);
            rny_reg <= tlqe_pkg::DIVNW'(ny_reg[tlqe_pkg::SQ_STAGES-1])
                     + tlqe_pkg::DIVNW'(den_next >> 1);
        end
    end

    tlqe_div u_div_x (
        .clk (clk),
        .en  (adv),
        .num (rnx_reg),
        .den (den_reg),
        .quo (qx)
    );

    tlqe_div u_div_y (
        .clk (clk),
        .en  (adv),
        .num (rny_reg),
        .den (den_reg),
        .quo (qy)
    );

    always_comb
    begin
        last = side_reg[tlqe_pkg::LAT-1];
        ox   = last.negx ? -tlqe_pkg::OFFW'(qx) : tlqe_pkg::OFFW'(qx);
        oy   = last.negy ? -tlqe_pkg::OFFW'(qy) : tlqe_pkg::OFFW'(qy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v_reg[tlqe_pkg::LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0x_reg <= tlqe_pkg::sat(tlqe_pkg::SUMW'(last.sx) + tlqe_pkg::SUMW'(ox));
            c0y_reg <= tlqe_pkg::sat(tlqe_pkg::SUMW'(last.sy) + tlqe_pkg::SUMW'(oy));
            c1x_reg <= tlqe_pkg::sat(tlqe_pkg::SUMW'(last.ex) + tlqe_pkg::SUMW'(ox));
            c1y_reg <= tlqe_pkg::sat(tlqe_pkg::SUMW'(last.ey) + tlqe_pkg::SUMW'(oy));
            c2x_reg <= tlqe_pkg::sat(tlqe_pkg::SUMW'(last.ex) - tlqe_pkg::SUMW'(ox));
            c2y_reg <= tlqe_pkg::sat(tlqe_pkg::SUMW'(last.ey) - tlqe_pkg::SUMW'(oy));
            c3x_reg <= tlqe_pkg::sat(tlqe_pkg::SUMW'(last.sx) - tlqe_pkg::SUMW'(ox));
            c3y_reg <= tlqe_pkg::sat(tlqe_pkg::SUMW'(last.sy) - tlqe_pkg::SUMW'(oy));
            degen_reg <= last.degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign corner0_x  = c0x_reg;
    assign corner0_y  = c0y_reg;
    assign corner1_x  = c1x_reg;
    assign corner1_y  = c1y_reg;
    assign corner2_x  = c2x_reg;
    assign corner2_y  = c2y_reg;
    assign corner3_x  = c3x_reg;
    assign corner3_y  = c3y_reg;
    assign degenerate = degen_reg;

    a_degen_collapse: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (corner0_x == corner2_x && corner0_y == corner2_y
                                       && corner1_x == corner3_x && corner1_y == corner3_y))
        else $error("degenerate transaction with nonzero offset");

    a_degen_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (corner0_x == corner1_x && corner0_y == corner1_y))
        else $error("degenerate transaction with distinct endpoints");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall not tied to output backpressure");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(corner2_x) && $stable(degenerate)))
        else $error("output transaction changed under stall");
endmodule
